// ----- hdl/mini_uart_register_block_defines.svh -----
// Assertion macros shared by the mini UART register block.
`ifndef MINI_UART_REGISTER_BLOCK_DEFINES_SVH
`define MINI_UART_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MUR_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MUR_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mur_pkg.sv -----
package mur_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RX    = 2'd2;

    // Register offsets.
    localparam logic [7:0] OFF_IRQ     = 8'h00;
    localparam logic [7:0] OFF_ENABLE  = 8'h04;
    localparam logic [7:0] OFF_IO      = 8'h40;
    localparam logic [7:0] OFF_IER     = 8'h44;
    localparam logic [7:0] OFF_IIR     = 8'h48;
    localparam logic [7:0] OFF_MCR     = 8'h50;
    localparam logic [7:0] OFF_LSR     = 8'h54;
    localparam logic [7:0] OFF_MSR     = 8'h58;
    localparam logic [7:0] OFF_SCRATCH = 8'h5c;
    localparam logic [7:0] OFF_CNTL    = 8'h60;
    localparam logic [7:0] OFF_STAT    = 8'h64;
    localparam logic [7:0] OFF_BAUD    = 8'h68;

    // Read values and bit fields.
    localparam logic [31:0] IIR_BASE   = 32'h0000_00c0;
    localparam logic [31:0] IIR_RX     = 32'h0000_0004;
    localparam logic [31:0] IIR_NONE   = 32'h0000_0002;
    localparam logic [31:0] IIR_IDLE   = 32'h0000_0001;
    localparam logic [31:0] LSR_BASE   = 32'h0000_0060;
    localparam logic [31:0] MSR_CTS    = 32'h0000_0010;
    localparam logic [31:0] MCR_RTS    = 32'h0000_0002;
    localparam logic [31:0] CNTL_VALUE = 32'h0000_0003;
    localparam logic [31:0] STAT_BASE  = 32'h0000_030e;
    localparam logic [31:0] STAT_DATA  = 32'h0000_0001;
    localparam int          STAT_FILL_SHIFT = 16;
    localparam logic [3:0]  ROOM_MAX   = 4'hf;

    // One input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  offset;
        logic [31:0] write_data;
        logic        cts_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rts_out;
        logic [3:0]  rx_room;
        logic        rx_dropped;
    } t_out_item;

endpackage

// ----- hdl/mur_if.sv -----
// Input item channel.
interface mur_in_if;
    import mur_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Result item channel.
interface mur_out_if;
    import mur_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/mini_uart_register_block.sv -----
// Mini UART register file. Each item (bus read, bus write or received byte) is taken
// into an input register, decoded against the register state and the receive FIFO,
// and its result is held in an output register. One item is accepted every cycle
// while results are being taken. The receive FIFO is a RX_DEPTH-entry memory with a
// registered read of the slot at the head pointer, refreshed every cycle with
// forwarding of a same-cycle write, so an IO read never waits. Entries never written
// since reset read as zero through per-entry valid bits; there is no clearing pass.
`include "mini_uart_register_block_defines.svh"

module mini_uart_register_block
    import mur_pkg::*;
#(
    parameter int RX_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mur_in_if.sink    i_item,
    mur_out_if.source o_result
);

    localparam int AW = $clog2(RX_DEPTH);
    localparam int FW = $clog2(RX_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(RX_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(RX_DEPTH - 1);
    localparam logic [AW:0]   SLOT_WRAP = (AW + 1)'(RX_DEPTH);

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      proc_fire;
    t_out_item n_out;

    // Register state.
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [1:0]    r_ien, n_ien;
    logic          r_rts, n_rts;
    logic [7:0]    r_enable, n_enable;
    logic [7:0]    r_scratch, n_scratch;

    // Receive FIFO storage.
    logic [7:0]          r_store [RX_DEPTH];
    logic [RX_DEPTH-1:0] r_stored;
    logic [7:0]          r_head_data;
    logic                r_head_valid;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                wr_fwd;

    // Decode helpers.
    logic          uart_on;
    logic          fill_nz;
    logic [1:0]    pend;
    logic [1:0]    n_pend;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] head_inc;
    logic [7:0]    head_byte;
    logic [FW-1:0] room_full;
    logic          rx_drop;

    // Handshake: the input register moves on whenever the result register frees up.
    assign proc_fire      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || proc_fire;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
    end

    // Current-state helpers.
    assign uart_on   = r_enable[0];
    assign fill_nz   = (r_fill != '0);
    assign pend      = {r_ien[1], r_ien[0] && fill_nz};
    assign slot_sum  = {1'b0, r_head} + (AW + 1)'(r_fill);
    assign wr_addr   = (slot_sum >= SLOT_WRAP) ? AW'(slot_sum - SLOT_WRAP) : AW'(slot_sum);
    assign wr_data   = r_in.write_data[7:0];
    assign head_inc  = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
    assign head_byte = r_head_valid ? r_head_data : 8'h00;

    // Decode and state update for the item in the input register.
    always_comb begin
        n_head    = r_head;
        n_fill    = r_fill;
        n_ien     = r_ien;
        n_rts     = r_rts;
        n_enable  = r_enable;
        n_scratch = r_scratch;
        wr_en     = 1'b0;
        rx_drop   = 1'b0;
        n_out     = '0;
        if (proc_fire) begin
            case (r_in.kind)
                KIND_READ: begin
                    if (r_in.offset inside {[OFF_IO:OFF_BAUD]} && !uart_on) begin
                        n_out.read_data = '0;
                    end else begin
                        case (r_in.offset)
                            OFF_IRQ:     n_out.read_data = {31'b0, |pend};
                            OFF_ENABLE:  n_out.read_data = {24'b0, r_enable};
                            OFF_IO: begin
                                n_out.read_data = {24'b0, head_byte};
                                if (fill_nz) begin
                                    n_fill = r_fill - FW'(1);
                                    n_head = head_inc;
                                end
                            end
                            OFF_IER:     n_out.read_data = {30'b0, r_ien};
                            OFF_IIR: begin
                                n_out.read_data = IIR_BASE | (pend[0] ? IIR_RX : IIR_NONE)
                                                  | ((pend == 2'b00) ? IIR_IDLE : '0);
                            end
                            OFF_MCR:     n_out.read_data = r_rts ? MCR_RTS : '0;
                            OFF_LSR:     n_out.read_data = LSR_BASE | {31'b0, fill_nz};
                            OFF_MSR:     n_out.read_data = r_in.cts_in ? MSR_CTS : '0;
                            OFF_SCRATCH: n_out.read_data = {24'b0, r_scratch};
                            OFF_CNTL:    n_out.read_data = CNTL_VALUE;
                            OFF_STAT: begin
                                n_out.read_data = fill_nz
                                    ? (STAT_BASE | STAT_DATA | (32'(r_fill) << STAT_FILL_SHIFT))
                                    : STAT_BASE;
                            end
                            default:     n_out.read_data = '0;
                        endcase
                    end
                end
                KIND_WRITE: begin
                    case (r_in.offset)
                        OFF_ENABLE:  n_enable = r_in.write_data[7:0];
                        OFF_IO: begin
                            if (uart_on) begin
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = r_in.write_data[7:0];
                            end
                        end
                        OFF_IER:     n_ien = r_in.write_data[1:0];
                        OFF_IIR: begin
                            if (r_in.write_data[1]) begin
                                n_head = '0;
                                n_fill = '0;
                            end
                        end
                        OFF_MCR:     n_rts = r_in.write_data[1];
                        OFF_SCRATCH: n_scratch = r_in.write_data[7:0];
                        default:     ;
                    endcase
                end
                KIND_RX: begin
                    if (uart_on) begin
                        if (r_fill >= FILL_FULL) begin
                            rx_drop = 1'b1;
                        end else begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + FW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        // Status fields reflect the state after the item.
        n_pend           = {n_ien[1], n_ien[0] && (n_fill != '0)};
        room_full        = FILL_FULL - n_fill;
        n_out.irq_line   = |n_pend;
        n_out.rts_out    = n_rts;
        n_out.rx_dropped = rx_drop;
        if (!n_enable[0]) begin
            n_out.rx_room = '0;
        end else if ((FW + 4)'(room_full) > (FW + 4)'(ROOM_MAX)) begin
            n_out.rx_room = ROOM_MAX;
        end else begin
            n_out.rx_room = 4'(room_full);
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_ien     <= '0;
            r_rts     <= 1'b0;
            r_enable  <= '0;
            r_scratch <= '0;
        end else begin
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_ien     <= n_ien;
            r_rts     <= n_rts;
            r_enable  <= n_enable;
            r_scratch <= n_scratch;
        end
    end

    // FIFO memory with a registered read of the next head slot.
    assign wr_fwd = wr_en && (wr_addr == n_head);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_head_data <= wr_fwd ? wr_data : r_store[n_head];
    end

    // Written-since-reset marks for the FIFO slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored     <= '0;
            r_head_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_stored[wr_addr] <= 1'b1;
            end
            r_head_valid <= r_stored[n_head] || wr_fwd;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire) begin
            r_out <= n_out;
        end
    end

    // Internal checks.
    `MUR_CHECK(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_FULL, "fill count past depth")
    `MUR_CHECK(a_head_bound, i_clk, i_rst_n, 1'b1, r_head <= HEAD_LAST, "head pointer out of range")
    `MUR_CHECK(a_drop_full, i_clk, i_rst_n, rx_drop, r_fill == FILL_FULL, "drop without full FIFO")
    `MUR_CHECK_NEXT(a_fire_result, i_clk, i_rst_n, proc_fire, r_out_valid, "processed item lost")

endmodule

// ----- test/mini_uart_register_block_tb.sv -----
module mini_uart_register_block_tb
    import mur_pkg::*;
();

    localparam int          RX_SLOTS        = 8;
    localparam int unsigned RANDOM_ITEMS    = 1650;
    localparam int unsigned HOLD_OFF_AT     = 400;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_AT        = 1100;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned RUN_LIMIT       = 200000;

    // Codes and bits that the package does not name.
    localparam logic [1:0]  KIND_NONE      = 2'd3;
    localparam logic [7:0]  OFF_LCR        = 8'h4c;
    localparam logic [7:0]  OFF_SPI_TOP    = 8'hff;
    localparam logic [7:0]  UART_ON_MASK   = 8'h01;
    localparam logic [31:0] IIR_CLEAR_FIFO = 32'h0000_0002;
    localparam logic [31:0] LSR_DATA_READY = 32'h0000_0001;
    localparam logic [1:0]  IRQ_RX         = 2'b01;
    localparam logic [1:0]  IRQ_TX         = 2'b10;

    typedef enum int unsigned {
        SINK_STEADY,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } t_sink_mode;

    // Register file mirror: keeps the FIFO and control state and queues the
    // response that each accepted item must produce.
    class t_uart_reg_scoreboard;
        logic [7:0]  rx_bytes [RX_SLOTS];
        int unsigned head;
        int unsigned fill;
        logic [1:0]  irq_enable;
        logic [1:0]  irq_pending;
        logic        rts;
        logic [7:0]  enables;
        logic [7:0]  scratch;
        t_out_item   due[$];
        int unsigned failures;

        function new();
            foreach (rx_bytes[i]) rx_bytes[i] = '0;
            head        = 0;
            fill        = 0;
            irq_enable  = '0;
            irq_pending = '0;
            rts         = 1'b0;
            enables     = '0;
            scratch     = '0;
            failures    = 0;
        endfunction

        function bit uart_on();
            return (enables & UART_ON_MASK) != 0;
        endfunction

        function void refresh_irq();
            irq_pending = '0;
            if ((irq_enable & IRQ_RX) != 0 && fill != 0) irq_pending |= IRQ_RX;
            if ((irq_enable & IRQ_TX) != 0) irq_pending |= IRQ_TX;
        endfunction

        function int unsigned outstanding();
            return due.size();
        endfunction

        // Value of a bus read; an IO read pops the FIFO.
        function logic [31:0] read_register(input logic [7:0] off, input logic cts);
            logic [31:0] value;
            if (off >= OFF_IO && off <= OFF_BAUD && !uart_on()) return '0;
            case (off)
                OFF_IRQ:     return (irq_pending != 0) ? 32'd1 : 32'd0;
                OFF_ENABLE:  return {24'd0, enables};
                OFF_IO: begin
                    value = {24'd0, rx_bytes[head % RX_SLOTS]};
                    if (fill > 0) begin
                        fill--;
                        head = (head + 1 >= RX_SLOTS) ? 0 : head + 1;
                    end
                    refresh_irq();
                    return value;
                end
                OFF_IER:     return {30'd0, irq_enable};
                OFF_IIR: begin
                    value = IIR_BASE;
                    value |= ((irq_pending & IRQ_RX) != 0 && fill != 0) ? IIR_RX : IIR_NONE;
                    if (irq_pending == 0) value |= IIR_IDLE;
                    return value;
                end
                OFF_MCR:     return rts ? MCR_RTS : '0;
                OFF_LSR:     return LSR_BASE | ((fill != 0) ? LSR_DATA_READY : '0);
                OFF_MSR:     return cts ? MSR_CTS : '0;
                OFF_SCRATCH: return {24'd0, scratch};
                OFF_CNTL:    return CNTL_VALUE;
                OFF_STAT: begin
                    value = STAT_BASE;
                    if (fill > 0) value |= STAT_DATA | (32'(fill) << STAT_FILL_SHIFT);
                    return value;
                end
                default:     return '0;
            endcase
        endfunction

        // Effect of a bus write; an IO write sends a byte while enabled.
        function void write_register(input logic [7:0] off, input logic [31:0] data,
                                     output logic sent, output logic [7:0] sent_data);
            sent      = 1'b0;
            sent_data = '0;
            case (off)
                OFF_ENABLE:  enables = data[7:0];
                OFF_IO: begin
                    if (uart_on()) begin
                        sent      = 1'b1;
                        sent_data = data[7:0];
                    end
                end
                OFF_IER:     irq_enable = data[1:0];
                OFF_IIR: begin
                    if ((data & IIR_CLEAR_FIFO) != 0) begin
                        head = 0;
                        fill = 0;
                    end
                end
                OFF_MCR:     rts = (data & MCR_RTS) != 0;
                OFF_SCRATCH: scratch = data[7:0];
                default: ;
            endcase
            refresh_irq();
        endfunction

        // Work out the response to an accepted item and queue it.
        function void note_item(input t_in_item it);
            t_out_item   res;
            int unsigned slot;
            int unsigned room;
            res = '0;
            case (it.kind)
                KIND_READ:  res.read_data = read_register(it.offset, it.cts_in);
                KIND_WRITE: write_register(it.offset, it.write_data, res.tx_valid, res.tx_byte);
                KIND_RX: begin
                    if (uart_on()) begin
                        if (fill >= RX_SLOTS) begin
                            res.rx_dropped = 1'b1;
                        end else begin
                            slot = (head + fill) % RX_SLOTS;
                            rx_bytes[slot] = it.write_data[7:0];
                            fill++;
                            refresh_irq();
                        end
                    end
                end
                default: ;
            endcase
            room = 0;
            if (uart_on()) begin
                room = (fill <= RX_SLOTS) ? RX_SLOTS - fill : 0;
                if (room > ROOM_MAX) room = ROOM_MAX;
            end
            res.irq_line = irq_pending != 0;
            res.rts_out  = rts;
            res.rx_room  = room[3:0];
            due.push_back(res);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                failures++;
            end
        endfunction

        // Compare a delivered response with the oldest one still due.
        function void check_response(input t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                $error("Response with nothing due: read_data %h", got.read_data);
                failures++;
                return;
            end
            want = due.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("irq_line", want.irq_line, got.irq_line);
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("rts_out", want.rts_out, got.rts_out);
            compare_field("rx_room", want.rx_room, got.rx_room);
            compare_field("rx_dropped", want.rx_dropped, got.rx_dropped);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    bit          hold_off_request = 1'b0;

    mur_in_if  item_ch ();
    mur_out_if result_ch ();

    t_uart_reg_scoreboard regs_sb = new();

    mini_uart_register_block #(
        .RX_DEPTH (RX_SLOTS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Clock and cycle count.
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("Run stopped at the cycle limit with %0d responses due.",
                 regs_sb.outstanding());
        $display("[mini_uart_register_block] ERROR");
        $finish;
    end

    // Every response taken by the sink is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            regs_sb.check_response(result_ch.payload);
        end
    end

    // The sink stalls on changing patterns, with one long hold-off on request.
    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned mode_left;
        result_ch.ready <= 1'b0;
        mode      = SINK_STEADY;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    SINK_STEADY: result_ch.ready <= 1'b1;
                    SINK_COIN:   result_ch.ready <= 1'($urandom_range(1));
                    SINK_SPARSE: result_ch.ready <= (mode_left % 4) == 0;
                    default:     result_ch.ready <= $urandom_range(3) != 0;
                endcase
            end
        end
    end

    // Offer one item and hold it until it is taken.
    task automatic offer_item(input t_in_item it);
        item_ch.payload <= it;
        item_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        regs_sb.note_item(it);
    endtask

    task automatic bus_read(input logic [7:0] off, input logic cts);
        t_in_item it;
        it = '{kind: KIND_READ, offset: off, write_data: $urandom(), cts_in: cts};
        offer_item(it);
    endtask

    task automatic bus_write(input logic [7:0] off, input logic [31:0] data);
        t_in_item it;
        it = '{kind: KIND_WRITE, offset: off, write_data: data,
               cts_in: 1'($urandom_range(1))};
        offer_item(it);
    endtask

    task automatic serial_rx(input logic [31:0] data);
        t_in_item it;
        it = '{kind: KIND_RX, offset: 8'($urandom_range(255)), write_data: data,
               cts_in: 1'($urandom_range(1))};
        offer_item(it);
    endtask

    // Stop offering and wait until every queued response has come back.
    task automatic wait_for_responses();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (regs_sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] pick_register();
        case ($urandom_range(12))
            0:       return OFF_IRQ;
            1:       return OFF_ENABLE;
            2:       return OFF_IO;
            3:       return OFF_IER;
            4:       return OFF_IIR;
            5:       return OFF_LCR;
            6:       return OFF_MCR;
            7:       return OFF_LSR;
            8:       return OFF_MSR;
            9:       return OFF_SCRATCH;
            10:      return OFF_CNTL;
            11:      return OFF_STAT;
            default: return OFF_BAUD;
        endcase
    endfunction

    // Mostly register traffic with random content; fill phases favor received
    // bytes so the FIFO overflows, drain phases favor IO reads.
    function automatic t_in_item random_uart_item(input bit drain_phase);
        t_in_item    it;
        int unsigned roll;
        it.write_data = $urandom();
        it.cts_in     = 1'($urandom_range(1));
        it.offset     = 8'($urandom_range(255));
        roll          = $urandom_range(99);
        if (roll < (drain_phase ? 18 : 50)) begin
            it.kind = KIND_RX;
        end else if (roll < (drain_phase ? 68 : 75)) begin
            it.kind = KIND_READ;
            roll = $urandom_range(99);
            if (roll < 45) it.offset = OFF_IO;
            else if (roll < 90) it.offset = pick_register();
        end else if (roll < 96) begin
            it.kind = KIND_WRITE;
            if ($urandom_range(99) < 88) it.offset = pick_register();
            // Keep the UART on most of the time.
            if (it.offset == OFF_ENABLE) it.write_data[0] = $urandom_range(99) >= 15;
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    // Reset, directed items, random bursts, then drain and report.
    initial begin : stimulus
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        bit          drain_phase;
        t_in_item    it;
        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled UART: reads of its bank are zero, bytes and sends are dropped,
        // while IER and MCR writes still land.
        bus_read(OFF_IO, 1'b0);
        serial_rx(32'h0000_005a);
        bus_write(OFF_IO, 32'h0000_0077);
        bus_write(OFF_IER, 32'hffff_ffff);
        bus_write(OFF_MCR, 32'hffff_ffff);
        bus_write(OFF_ENABLE, 32'hffff_ffff);
        bus_read(OFF_ENABLE, 1'b0);
        bus_read(OFF_IIR, 1'b0);
        bus_read(OFF_MSR, 1'b1);
        bus_read(OFF_IRQ, 1'b1);
        bus_read(OFF_SPI_TOP, 1'b1);

        // Fill the FIFO to the top; the last byte overflows.
        serial_rx(32'h0000_0000);
        serial_rx(32'hffff_ffff);
        repeat (RX_SLOTS - 1) serial_rx($urandom());
        bus_read(OFF_STAT, 1'b0);
        bus_read(OFF_IIR, 1'b0);
        bus_read(OFF_IO, 1'b0);
        bus_write(OFF_IO, 32'h0000_00ff);

        // Clear the FIFO, then read it empty.
        bus_write(OFF_IIR, IIR_CLEAR_FIFO);
        bus_read(OFF_IO, 1'b0);
        it = '{kind: KIND_NONE, offset: 8'hff, write_data: 32'hffff_ffff, cts_in: 1'b1};
        offer_item(it);
        bus_write(OFF_ENABLE, 32'h0000_0000);
        bus_read(OFF_STAT, 1'b1);
        wait_for_responses();

        // Random traffic in bursts.
        bus_write(OFF_ENABLE, {24'd0, UART_ON_MASK});
        sent        = 0;
        drain_phase = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && sent < RANDOM_ITEMS) begin
                if (sent % 50 == 0) drain_phase = 1'($urandom_range(1));
                if (sent == HOLD_OFF_AT) hold_off_request = 1'b1;
                if (sent == DRAIN_AT) wait_for_responses();
                it = random_uart_item(drain_phase);
                offer_item(it);
                if (it.kind != KIND_NONE) sent++;
                burst--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (regs_sb.failures == 0 && regs_sb.outstanding() == 0) begin
            $display("[mini_uart_register_block] OK");
        end else begin
            $display("[mini_uart_register_block] ERROR");
        end
        $finish;
    end

endmodule
